@@ hdl/gspd_pkg.sv @@
// Package: shared types, codes and constants for the simple-packing decoder.
package gspd_pkg;

	localparam logic [63:0] DBL_ONE         = 64'h3FF0_0000_0000_0000;
	localparam logic [63:0] DBL_DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
	localparam logic [6:0]  BPV_RESET       = 7'd8;
	localparam logic [6:0]  BPV_MAX         = 7'd64;

	// Register indexes on the configuration port
	typedef enum logic [2:0] {
		REG_BPV = 3'd0,
		REG_REF = 3'd1,
		REG_BSC = 3'd2,
		REG_DSC = 3'd3,
		REG_CNT = 3'd4
	} reg_idx_t;

	// Operations of the shared floating-point unit
	typedef enum logic [1:0] {
		FOP_CVT = 2'd0,
		FOP_MUL = 2'd1,
		FOP_ADD = 2'd2
	} fpu_op_t;

	typedef struct packed {
		logic    start;
		fpu_op_t op;
	} fpu_req_t;

	typedef struct packed {
		logic idle;
		logic done;
	} fpu_rsp_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_MUL,
		F_ADD,
		F_NORM,
		F_DENORM,
		F_ROUND,
		F_DONE
	} fpu_state_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXTRACT,
		S_CVT,
		S_MUL1,
		S_ADD,
		S_MUL2,
		S_OUT
	} seq_state_t;

endpackage

@@ hdl/gspd_fpu.sv @@
// Shared multi-cycle double unit: u64 conversion, multiply and add, round to nearest even.
module gspd_fpu (
	input  logic               clk,
	input  logic               arst_n,
	input  gspd_pkg::fpu_req_t req,
	input  logic [63:0]        opa,
	input  logic [63:0]        opb,
	output gspd_pkg::fpu_rsp_t rsp,
	output logic [63:0]        result
);
	import gspd_pkg::*;

	fpu_state_t state_q, state_d;

	logic [127:0]       w_q;
	logic signed [13:0] ew_q;
	logic               sgn_q, zsgn_q, sub_q;
	logic [52:0]        ma_q, mb_q;
	logic [1:0]         step_q;
	logic [63:0]        rsig_q;
	logic               rst_q;
	logic [10:0]        rexp_q;
	logic [63:0]        res_q;

	// Operand fields
	logic        sa, sb;
	logic [10:0] exa, exb, efa, efb;
	logic [51:0] fra, frb;
	logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
	logic [52:0] mant_a, mant_b;
	logic signed [13:0] ea, eb;

	always_comb begin
		sa     = opa[63];
		sb     = opb[63];
		exa    = opa[62:52];
		exb    = opb[62:52];
		fra    = opa[51:0];
		frb    = opb[51:0];
		nan_a  = (exa == 11'h7FF) && (fra != '0);
		nan_b  = (exb == 11'h7FF) && (frb != '0);
		inf_a  = (exa == 11'h7FF) && (fra == '0);
		inf_b  = (exb == 11'h7FF) && (frb == '0);
		zero_a = (opa[62:0] == '0);
		zero_b = (opb[62:0] == '0);
		mant_a = {exa != '0, fra};
		mant_b = {exb != '0, frb};
		efa    = (exa == '0) ? 11'd1 : exa;
		efb    = (exb == '0) ? 11'd1 : exb;
		ea     = $signed({3'b000, efa}) - 14'sd1075;
		eb     = $signed({3'b000, efb}) - 14'sd1075;
	end

	// Multiply specials: NaN propagation first operand first, invalid, infinity
	logic        spec_mul;
	logic [63:0] spec_mul_val;
	always_comb begin
		spec_mul     = 1'b1;
		spec_mul_val = '0;
		if (nan_a) begin
			spec_mul_val = opa | (64'd1 << 51);
		end else if (nan_b) begin
			spec_mul_val = opb | (64'd1 << 51);
		end else if ((inf_a && zero_b) || (zero_a && inf_b)) begin
			spec_mul_val = DBL_DEFAULT_NAN;
		end else if (inf_a || inf_b) begin
			spec_mul_val = {sa ^ sb, 11'h7FF, 52'd0};
		end else begin
			spec_mul = 1'b0;
		end
	end

	// Add specials
	logic        spec_add;
	logic [63:0] spec_add_val;
	always_comb begin
		spec_add     = 1'b1;
		spec_add_val = '0;
		if (nan_a) begin
			spec_add_val = opa | (64'd1 << 51);
		end else if (nan_b) begin
			spec_add_val = opb | (64'd1 << 51);
		end else if (inf_a && inf_b && (sa != sb)) begin
			spec_add_val = DBL_DEFAULT_NAN;
		end else if (inf_a) begin
			spec_add_val = opa;
		end else if (inf_b) begin
			spec_add_val = opb;
		end else begin
			spec_add = 1'b0;
		end
	end

	// Align the smaller magnitude under the larger, jam lost bits into bit 0
	logic               a_big, big_s;
	logic [52:0]        big_m, small_m;
	logic [10:0]        big_ef, small_ef, diff;
	logic [127:0]       xs, al_mask, al_val;
	logic               al_sticky;
	logic signed [13:0] ew_add;
	always_comb begin
		a_big    = opa[62:0] >= opb[62:0];
		big_s    = a_big ? sa : sb;
		big_m    = a_big ? mant_a : mant_b;
		small_m  = a_big ? mant_b : mant_a;
		big_ef   = a_big ? efa : efb;
		small_ef = a_big ? efb : efa;
		diff     = big_ef - small_ef;
		xs       = {1'b0, small_m, 74'd0};
		al_mask  = (128'd1 << diff[6:0]) - 128'd1;
		if (diff >= 11'd128) begin
			al_val    = '0;
			al_sticky = |small_m;
		end else begin
			al_val    = xs >> diff[6:0];
			al_sticky = |(xs & al_mask);
		end
		ew_add = $signed({3'b000, big_ef}) - 14'sd1149;
	end

	// Partial products of the 53x53 mantissa product, one per cycle
	logic [26:0]  mul_x, mul_y;
	logic [53:0]  pp;
	logic [127:0] pp_sh;
	always_comb begin
		mul_x = step_q[1] ? {1'b0, ma_q[52:27]} : ma_q[26:0];
		mul_y = step_q[0] ? {1'b0, mb_q[52:27]} : mb_q[26:0];
		pp    = mul_x * mul_y;
		case (step_q)
			2'd0:    pp_sh = {74'd0, pp};
			2'd3:    pp_sh = {74'd0, pp} << 54;
			default: pp_sh = {74'd0, pp} << 27;
		endcase
	end

	// Add or subtract the aligned magnitudes
	logic [127:0] xb, sum;
	always_comb begin
		xb  = {1'b0, ma_q, 74'd0};
		sum = sub_q ? (xb - w_q) : (xb + w_q);
	end

	// Normalize step: coarse then fine
	logic [127:0]       norm_w;
	logic signed [13:0] norm_ew;
	always_comb begin
		if (w_q[127:96] == '0) begin
			norm_w  = w_q << 32;
			norm_ew = ew_q - 14'sd32;
		end else if (w_q[127:120] == '0) begin
			norm_w  = w_q << 8;
			norm_ew = ew_q - 14'sd8;
		end else begin
			norm_w  = w_q << 1;
			norm_ew = ew_q - 14'sd1;
		end
	end

	// Biased exponent, overflow and subnormal shift
	logic signed [13:0] be, sh_amt;
	logic [63:0]        sig, dn_sig, dn_mask;
	logic               stk, dn_st, ovf;
	logic [10:0]        dn_exp;
	always_comb begin
		be      = ew_q + 14'sd1150;
		sig     = w_q[127:64];
		stk     = |w_q[63:0];
		ovf     = be >= 14'sd2047;
		sh_amt  = 14'sd1 - be;
		dn_mask = (64'd1 << sh_amt[5:0]) - 64'd1;
		if (be >= 14'sd1) begin
			dn_sig = sig;
			dn_st  = stk;
			dn_exp = be[10:0];
		end else if (sh_amt >= 14'sd64) begin
			dn_sig = '0;
			dn_st  = stk | (|sig);
			dn_exp = '0;
		end else begin
			dn_sig = sig >> sh_amt[5:0];
			dn_st  = stk | (|(sig & dn_mask));
			dn_exp = '0;
		end
	end

	// Round to nearest even; carry runs into the exponent field
	logic        rinc;
	logic [62:0] packed_mag;
	always_comb begin
		rinc       = rsig_q[10] && ((|rsig_q[9:0]) || rst_q || rsig_q[11]);
		packed_mag = {rexp_q, rsig_q[62:11]} + {62'd0, rinc};
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (req.start) begin
					case (req.op)
						FOP_CVT: state_d = F_NORM;
						FOP_MUL: state_d = spec_mul ? F_DONE : F_MUL;
						FOP_ADD: state_d = spec_add ? F_DONE : F_ADD;
						default: state_d = F_IDLE;
					endcase
				end
			end
			F_MUL:    if (step_q == 2'd3) state_d = F_NORM;
			F_ADD:    state_d = F_NORM;
			F_NORM: begin
				if (w_q == '0 || w_q[127]) state_d = (w_q == '0) ? F_DONE : F_DENORM;
			end
			F_DENORM: state_d = ovf ? F_DONE : F_ROUND;
			F_ROUND:  state_d = F_DONE;
			F_DONE:   state_d = F_IDLE;
			default:  state_d = F_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		rsp.idle = (state_q == F_IDLE);
		rsp.done = (state_q == F_DONE);
		result   = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (req.start) begin
					case (req.op)
						FOP_CVT: begin
							w_q   <= {64'd0, opa};
							ew_q  <= '0;
							sgn_q <= 1'b0;
						end
						FOP_MUL: begin
							res_q  <= spec_mul_val;
							w_q    <= '0;
							ew_q   <= ea + eb;
							sgn_q  <= sa ^ sb;
							ma_q   <= mant_a;
							mb_q   <= mant_b;
							step_q <= '0;
						end
						FOP_ADD: begin
							res_q  <= spec_add_val;
							w_q    <= al_val | {127'd0, al_sticky};
							ew_q   <= ew_add;
							sgn_q  <= big_s;
							zsgn_q <= sa & sb;
							sub_q  <= sa ^ sb;
							ma_q   <= big_m;
						end
						default: ;
					endcase
				end
			end
			F_MUL: begin
				w_q    <= w_q + pp_sh;
				step_q <= step_q + 2'd1;
			end
			F_ADD: begin
				w_q <= sum;
				if (sum == '0) sgn_q <= zsgn_q;
			end
			F_NORM: begin
				if (w_q == '0) begin
					res_q <= {sgn_q, 63'd0};
				end else if (!w_q[127]) begin
					w_q  <= norm_w;
					ew_q <= norm_ew;
				end
			end
			F_DENORM: begin
				res_q  <= {sgn_q, 11'h7FF, 52'd0};
				rsig_q <= dn_sig;
				rst_q  <= dn_st;
				rexp_q <= dn_exp;
			end
			F_ROUND: res_q <= {sgn_q, packed_mag};
			default: ;
		endcase
	end

endmodule

@@ hdl/grib_simple_packing_decoder.sv @@
// Top level: register port, bit extraction, scaling sequencer and output register.
// Flow: a byte that completes no value passes through the idle and extract states. A completed value
// is extracted, then converted, multiplied, added and multiplied on the shared double unit (four
// partial products per multiply plus a normalize loop), then registered in the output state,
// which waits while the output stalls.
// Throughput: one byte at a time. Reset clears the control state and restores register defaults.
module grib_simple_packing_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] value_bits,
	output logic        last_value
);
	import gspd_pkg::*;

	seq_state_t state_q, state_d;

	logic [6:0]  bpv_q;
	logic [63:0] ref_q, bsc_q, dsc_q;
	logic [31:0] cnt_q;
	logic [63:0] acc_q;
	logic [6:0]  held_q;
	logic [31:0] left_q;
	logic [7:0]  byte_q;
	logic [3:0]  bleft_q;
	logic [63:0] tmp_q;
	logic        issued_q;
	logic        out_valid_q, out_last_q;
	logic [63:0] out_bits_q;

	fpu_req_t    fpu_req;
	fpu_rsp_t    fpu_rsp;
	logic [63:0] fpu_opb, fpu_res;

	logic     cfg_wr;
	reg_idx_t cfg_idx;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[5:3]);
	assign pready  = 1'b1;

	// Register read
	always_comb begin
		case (cfg_idx)
			REG_BPV: prdata = {57'd0, bpv_q};
			REG_REF: prdata = ref_q;
			REG_BSC: prdata = bsc_q;
			REG_DSC: prdata = dsc_q;
			REG_CNT: prdata = {32'd0, cnt_q};
			default: prdata = '0;
		endcase
	end

	// Clamp the width to 1..64
	logic [6:0] width_eff;
	always_comb begin
		if (bpv_q == '0)          width_eff = 7'd1;
		else if (bpv_q > BPV_MAX) width_eff = BPV_MAX;
		else                      width_eff = bpv_q;
	end

	// Take as many bits of the byte as the current value still needs
	logic [6:0]  need;
	logic [3:0]  take;
	logic [7:0]  chunk;
	logic [63:0] acc_next;
	logic        complete, extracting;
	always_comb begin
		need       = width_eff - held_q;
		take       = (need > {3'd0, bleft_q}) ? bleft_q : need[3:0];
		chunk      = byte_q >> (4'd8 - take);
		acc_next   = (acc_q << take) | {56'd0, chunk};
		complete   = (held_q + {3'd0, take}) == width_eff;
		extracting = (left_q != '0) && (bleft_q != '0);
	end

	logic fp_state, out_free;
	assign fp_state = (state_q == S_CVT) || (state_q == S_MUL1) ||
	                  (state_q == S_ADD) || (state_q == S_MUL2);
	assign out_free = !out_valid_q || !out_stall;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:    if (in_valid) state_d = S_EXTRACT;
			S_EXTRACT: state_d = (extracting && complete) ? S_CVT : S_IDLE;
			S_CVT:     if (fpu_rsp.done) state_d = S_MUL1;
			S_MUL1:    if (fpu_rsp.done) state_d = S_ADD;
			S_ADD:     if (fpu_rsp.done) state_d = S_MUL2;
			S_MUL2:    if (fpu_rsp.done) state_d = S_OUT;
			S_OUT: begin
				if (out_free) state_d = (extracting) ? S_EXTRACT : S_IDLE;
			end
			default:   state_d = S_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		in_stall      = (state_q != S_IDLE);
		fpu_req.start = fp_state && !issued_q && fpu_rsp.idle;
		case (state_q)
			S_MUL1:  begin fpu_req.op = FOP_MUL; fpu_opb = bsc_q; end
			S_ADD:   begin fpu_req.op = FOP_ADD; fpu_opb = ref_q; end
			S_MUL2:  begin fpu_req.op = FOP_MUL; fpu_opb = dsc_q; end
			default: begin fpu_req.op = FOP_CVT; fpu_opb = '0;    end
		endcase
	end

	gspd_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fpu_req),
		.opa    (tmp_q),
		.opb    (fpu_opb),
		.rsp    (fpu_rsp),
		.result (fpu_res)
	);

	// Control state, configuration and bit accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			bpv_q       <= BPV_RESET;
			ref_q       <= '0;
			bsc_q       <= DBL_ONE;
			dsc_q       <= DBL_ONE;
			cnt_q       <= '0;
			acc_q       <= '0;
			held_q      <= '0;
			left_q      <= '0;
			bleft_q     <= '0;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				case (cfg_idx)
					REG_BPV: begin
						bpv_q  <= pwdata[6:0];
						acc_q  <= '0;
						held_q <= '0;
					end
					REG_REF: ref_q <= pwdata;
					REG_BSC: bsc_q <= pwdata;
					REG_DSC: dsc_q <= pwdata;
					REG_CNT: begin
						cnt_q  <= pwdata[31:0];
						left_q <= pwdata[31:0];
						acc_q  <= '0;
						held_q <= '0;
					end
					default: ;
				endcase
			end else if (state_q == S_IDLE && in_valid) begin
				bleft_q <= 4'd8;
			end else if (state_q == S_EXTRACT && extracting) begin
				bleft_q <= bleft_q - take;
				if (complete) begin
					acc_q  <= '0;
					held_q <= '0;
					left_q <= left_q - 32'd1;
				end else begin
					acc_q  <= acc_next;
					held_q <= held_q + {3'd0, take};
				end
			end

			// Track the request handed to the shared unit
			if (fpu_req.start)     issued_q <= 1'b1;
			else if (fpu_rsp.done) issued_q <= 1'b0;

			// Hold the result until the transfer completes
			if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
			else if (!out_stall)              out_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) byte_q <= data_byte;
		else if (state_q == S_EXTRACT)     byte_q <= byte_q << take;
		if (state_q == S_EXTRACT && complete) tmp_q <= acc_next;
		else if (fp_state && fpu_rsp.done)    tmp_q <= fpu_res;
		if (state_q == S_OUT && out_free) begin
			out_bits_q <= tmp_q;
			out_last_q <= (left_q == '0);
		end
	end

	assign out_valid  = out_valid_q;
	assign value_bits = out_bits_q;
	assign last_value = out_last_q;

	// Partial value never reaches the width
	a_held_below_width: assert property (@(posedge clk) disable iff (!arst_n)
		held_q < width_eff)
		else $error("bit count reached the value width");

	// The shared unit only finishes while the sequencer waits on it
	a_done_in_fp_state: assert property (@(posedge clk) disable iff (!arst_n)
		fpu_rsp.done |-> fp_state && issued_q)
		else $error("floating-point unit finished outside a scaling step");

	// A new operation starts only on an idle unit, which then leaves its idle state
	a_start_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fpu_req.start |=> !fpu_rsp.idle)
		else $error("floating-point request not taken");

endmodule
